/* rtl/hsfr_pkg.sv */
// ----------------------------------------------------------------------------
// hsfr_pkg
// Shared types and constants of the header-synced frame receiver.
// ----------------------------------------------------------------------------
package hsfr_pkg;

	// Frame geometry
	localparam int          FRAME_LENGTH = 19;
	localparam int          COUNT_W      = 7;
	localparam logic [COUNT_W-1:0] FRAME_LEN_C = COUNT_W'(FRAME_LENGTH);

	// Header pattern and the bytes it is made of
	localparam logic [7:0]  HDR_BYTE0    = 8'h55;
	localparam logic [7:0]  HDR_BYTE1    = 8'h01;
	localparam logic [7:0]  HDR_BYTE2    = 8'h00;
	localparam logic [23:0] HDR_PATTERN  = {HDR_BYTE0, HDR_BYTE1, HDR_BYTE2};

	// Timeout register reset value and idle count ceiling
	localparam logic [15:0] GAP_TIMEOUT_RST = 16'd100;
	localparam logic [15:0] IDLE_MAX        = 16'hffff;

	// Result queue geometry
	localparam int          RQ_DEPTH = 4;
	localparam int          RQ_PTR_W = $clog2(RQ_DEPTH);
	localparam int          RQ_CNT_W = $clog2(RQ_DEPTH + 1);
	localparam int          MAX_RES  = 3;

	// Input operation codes
	typedef enum logic {
		OP_BYTE = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	// Result kinds
	typedef enum logic {
		KIND_BYTE    = 1'b0,
		KIND_DISCARD = 1'b1
	} kind_t;

	// One result transaction
	typedef struct packed {
		kind_t      kind;
		logic [7:0] frame_byte;
		logic [5:0] byte_index;
		logic       frame_last;
		logic [6:0] discard_length;
	} result_t;

endpackage

/* rtl/header_synced_frame_receiver.sv */
// ----------------------------------------------------------------------------
// header_synced_frame_receiver
// Hunts for the 55 01 00 header in a byte stream, then passes on a
// fixed-length frame with indices; drops a partial frame after a tick gap.
// ----------------------------------------------------------------------------
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-----------------------------------------
//  input    | in_valid / in_ready   | operation, rx_byte
//  output   | out_valid / out_ready | out_kind, frame_byte, byte_index,
//           |                       | frame_last, discard_length
//  config   | cfg_we                | cfg_wdata (gap timeout, ticks)
//
//  An input transaction is registered, then processed combinationally against
//  the receiver state; its 0 to 3 results go into a 4-entry result queue.
//  One input transaction per cycle is accepted while the queue has room for
//  the results of the registered one; results leave one per cycle while
//  out_ready is high, and a header match yields three results.
//  Reset clears the state, the input register and the queue at once.
//  A stalled output holds the input side once the queue lacks room for all
//  results of the registered transaction.
//
module header_synced_frame_receiver (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        operation,
	input  logic [7:0]  rx_byte,
	// output channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic        out_kind,
	output logic [7:0]  frame_byte,
	output logic [5:0]  byte_index,
	output logic        frame_last,
	output logic [6:0]  discard_length,
	// configuration
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	localparam int CW = hsfr_pkg::COUNT_W;
	localparam int PW = hsfr_pkg::RQ_PTR_W;
	localparam int NW = hsfr_pkg::RQ_CNT_W;

	// input register
	logic        valid_s1;
	logic        op_s1;
	logic [7:0]  byte_s1;

	// receiver state
	logic [15:0]   gap_timeout_q;
	logic          capturing_q;
	logic [23:0]   history_q;
	logic [CW-1:0] count_q;
	logic [15:0]   idle_q;

	// result queue
	hsfr_pkg::result_t rq_mem_q [hsfr_pkg::RQ_DEPTH];
	logic [PW-1:0] rq_wr_q;
	logic [PW-1:0] rq_rd_q;
	logic [NW-1:0] rq_cnt_q;

	// processing results
	hsfr_pkg::result_t res   [hsfr_pkg::MAX_RES];
	logic [1:0]        res_n;
	logic              capturing_d;
	logic [23:0]       history_d;
	logic [CW-1:0]     count_d;
	logic [15:0]       idle_d;
	logic              advance;
	logic              pop;
	logic [16:0]       idle_inc;
	logic [23:0]       history_sh;
	logic [CW-1:0]     count_inc;
	logic              hdr_ok;

	// Process the registered transaction
	always_comb begin
		res_n       = 2'd0;
		capturing_d = capturing_q;
		history_d   = history_q;
		count_d     = count_q;
		idle_d      = idle_q;
		idle_inc    = {1'b0, idle_q} + 17'd1;
		history_sh  = {history_q[15:0], byte_s1};
		count_inc   = count_q + CW'(1);
		hdr_ok      = (byte_s1 == hsfr_pkg::HDR_BYTE0) || (byte_s1 == hsfr_pkg::HDR_BYTE1) ||
		              (byte_s1 == hsfr_pkg::HDR_BYTE2);
		for (int i = 0; i < hsfr_pkg::MAX_RES; i++) begin
			res[i] = '{kind: hsfr_pkg::KIND_BYTE, frame_byte: 8'd0, byte_index: 6'd0,
			           frame_last: 1'b0, discard_length: 7'd0};
		end

		if (op_s1 == hsfr_pkg::OP_TICK) begin
			// advance the gap counter, drop a stale partial frame
			if (capturing_q && (idle_inc > {1'b0, gap_timeout_q})) begin
				res[0].kind           = hsfr_pkg::KIND_DISCARD;
				res[0].discard_length = count_q;
				res_n       = 2'd1;
				capturing_d = 1'b0;
				count_d     = '0;
			end
			idle_d = idle_inc[16] ? hsfr_pkg::IDLE_MAX : idle_inc[15:0];
		end else begin
			idle_d = '0;
			if (!capturing_q) begin
				// hunt: keep only header bytes in the history
				if (!hdr_ok) begin
					count_d = '0;
				end else begin
					history_d = history_sh;
					count_d   = count_inc;
					if (history_sh == hsfr_pkg::HDR_PATTERN) begin
						res[0].frame_byte = hsfr_pkg::HDR_BYTE0;
						res[0].byte_index = 6'd0;
						res[1].frame_byte = hsfr_pkg::HDR_BYTE1;
						res[1].byte_index = 6'd1;
						res[2].frame_byte = hsfr_pkg::HDR_BYTE2;
						res[2].byte_index = 6'd2;
						res_n       = 2'd3;
						count_d     = CW'(3);
						capturing_d = 1'b1;
					end
				end
			end else begin
				// capture: pass the byte on with its index
				res[0].frame_byte = byte_s1;
				res[0].byte_index = count_q[5:0];
				res[0].frame_last = (count_inc >= hsfr_pkg::FRAME_LEN_C);
				res_n   = 2'd1;
				count_d = count_inc;
				if (count_inc >= hsfr_pkg::FRAME_LEN_C) begin
					capturing_d = 1'b0;
					count_d     = '0;
				end
			end
		end
	end

	// Handshakes
	assign advance   = valid_s1 && ((NW+1)'(rq_cnt_q) + (NW+1)'(res_n) <=
	                                (NW+1)'(hsfr_pkg::RQ_DEPTH));
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = (rq_cnt_q != '0);
	assign pop       = out_valid && out_ready;

	// Hold input register, state and queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			gap_timeout_q <= hsfr_pkg::GAP_TIMEOUT_RST;
			capturing_q   <= 1'b0;
			history_q     <= '0;
			count_q       <= '0;
			idle_q        <= '0;
			rq_wr_q       <= '0;
			rq_rd_q       <= '0;
			rq_cnt_q      <= '0;
		end else begin
			if (cfg_we) begin
				gap_timeout_q <= cfg_wdata;
			end
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				capturing_q <= capturing_d;
				history_q   <= history_d;
				count_q     <= count_d;
				idle_q      <= idle_d;
				rq_wr_q     <= rq_wr_q + PW'(res_n);
			end
			if (pop) begin
				rq_rd_q <= rq_rd_q + PW'(1);
			end
			rq_cnt_q <= rq_cnt_q + (advance ? NW'(res_n) : NW'(0)) - (pop ? NW'(1) : NW'(0));
		end
	end

	// Load input payload and queue entries
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1   <= operation;
			byte_s1 <= rx_byte;
		end
		if (advance) begin
			for (int i = 0; i < hsfr_pkg::MAX_RES; i++) begin
				if (2'(i) < res_n) begin
					rq_mem_q[rq_wr_q + PW'(i)] <= res[i];
				end
			end
		end
	end

	// Drive the head of the queue
	assign out_kind       = rq_mem_q[rq_rd_q].kind;
	assign frame_byte     = rq_mem_q[rq_rd_q].frame_byte;
	assign byte_index     = rq_mem_q[rq_rd_q].byte_index;
	assign frame_last     = rq_mem_q[rq_rd_q].frame_last;
	assign discard_length = rq_mem_q[rq_rd_q].discard_length;

	// Checks
	a_rq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rq_cnt_q <= NW'(hsfr_pkg::RQ_DEPTH))
		else $error("result queue overflow");

	a_cap_range: assert property (@(posedge clk) disable iff (!arst_n)
		capturing_q |-> (count_q >= CW'(3)) && (count_q < hsfr_pkg::FRAME_LEN_C))
		else $error("capture count out of frame range");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1)
		else $error("input stalled with empty input register");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res_n == 2'd1 && res[0].frame_last) |=> !capturing_q && count_q == '0)
		else $error("capture not closed after last byte");

	a_hdr_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res_n == 2'd3) |=> capturing_q && count_q == CW'(3))
		else $error("capture not started after header");

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the header-synced frame receiver: queued bytes and
// ticks go in over valid/ready, a tracker of the receiver state predicts each
// delivered byte and discard, and every output transaction is checked.
// ----------------------------------------------------------------------------
module tb;

	localparam int LONG_HOLD   = 300;
	localparam int SETTLE_CYC  = 8;
	localparam int TICK_SPAN   = 12;

	typedef struct {
		hsfr_pkg::op_t op;
		logic [7:0]    data;
		bit            burst;
	} rx_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        operation = hsfr_pkg::OP_BYTE;
	logic [7:0]  rx_byte = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        out_kind;
	logic [7:0]  frame_byte;
	logic [5:0]  byte_index;
	logic        frame_last;
	logic [6:0]  discard_length;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = 16'h0000;

	// Stimulus and expectations
	rx_item_t          rx_item_q[$];
	hsfr_pkg::result_t due_results[$];
	int          mismatch_cnt = 0;
	int          items_queued = 0;
	int          tmo_now = hsfr_pkg::GAP_TIMEOUT_RST;
	bit          jitter_on = 1'b1;
	bit          burst_mode = 1'b0;
	bit          in_fire = 1'b0;
	int          hold_req = 0;
	int          hold_done = 0;
	int          hold_left = 0;
	int          stall_left = 0;
	int          send_gap = 0;

	// Tracked receiver state
	bit          trk_capturing = 1'b0;
	logic [23:0] trk_history = '0;
	logic [6:0]  trk_count = '0;
	logic [15:0] trk_idle = '0;
	logic [15:0] trk_timeout = hsfr_pkg::GAP_TIMEOUT_RST;

	header_synced_frame_receiver i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.operation      (operation),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_kind       (out_kind),
		.frame_byte     (frame_byte),
		.byte_index     (byte_index),
		.frame_last     (frame_last),
		.discard_length (discard_length),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Mostly short gaps, a few long ones
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic push_result(input hsfr_pkg::kind_t k, input logic [7:0] b,
			input logic [5:0] idx, input logic last, input logic [6:0] dlen);
		hsfr_pkg::result_t r;
		r.kind           = k;
		r.frame_byte     = b;
		r.byte_index     = idx;
		r.frame_last     = last;
		r.discard_length = dlen;
		due_results.push_back(r);
	endtask

	// Advance the tracked receiver by one input transaction
	task automatic step_frame_tracker(input hsfr_pkg::op_t op, input logic [7:0] data);
		logic [16:0] next_idle;
		logic [5:0]  idx;
		if (op == hsfr_pkg::OP_TICK) begin
			next_idle = {1'b0, trk_idle} + 17'd1;
			if (trk_capturing && next_idle > {1'b0, trk_timeout}) begin
				push_result(hsfr_pkg::KIND_DISCARD, 8'h00, 6'd0, 1'b0, trk_count);
				trk_capturing = 1'b0;
				trk_count     = '0;
			end
			trk_idle = next_idle[16] ? hsfr_pkg::IDLE_MAX : next_idle[15:0];
		end else begin
			trk_idle = '0;
			if (!trk_capturing) begin
				// hunting: only header bytes enter the history
				if (data != hsfr_pkg::HDR_BYTE0 && data != hsfr_pkg::HDR_BYTE1 &&
						data != hsfr_pkg::HDR_BYTE2) begin
					trk_count = '0;
				end else begin
					trk_history = {trk_history[15:0], data};
					trk_count   = trk_count + 7'd1;
					if (trk_history == hsfr_pkg::HDR_PATTERN) begin
						push_result(hsfr_pkg::KIND_BYTE, hsfr_pkg::HDR_BYTE0, 6'd0, 1'b0, 7'd0);
						push_result(hsfr_pkg::KIND_BYTE, hsfr_pkg::HDR_BYTE1, 6'd1, 1'b0, 7'd0);
						push_result(hsfr_pkg::KIND_BYTE, hsfr_pkg::HDR_BYTE2, 6'd2, 1'b0, 7'd0);
						trk_count     = 7'd3;
						trk_capturing = 1'b1;
					end
				end
			end else begin
				idx       = trk_count[5:0];
				trk_count = trk_count + 7'd1;
				push_result(hsfr_pkg::KIND_BYTE, data, idx,
					trk_count >= hsfr_pkg::FRAME_LEN_C, 7'd0);
				if (trk_count >= hsfr_pkg::FRAME_LEN_C) begin
					trk_capturing = 1'b0;
					trk_count     = '0;
				end
			end
		end
	endtask

	task automatic cmp_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
			mismatch_cnt++;
		end
	endtask

	task automatic check_result();
		hsfr_pkg::result_t want;
		if (due_results.size() == 0) begin
			$display("%0t: unexpected result kind %0b byte %0h index %0d last %0b length %0d",
				$time, out_kind, frame_byte, byte_index, frame_last, discard_length);
			mismatch_cnt++;
		end else begin
			want = due_results.pop_front();
			cmp_field("out_kind", 8'(want.kind), 8'(out_kind));
			cmp_field("frame_byte", want.frame_byte, frame_byte);
			cmp_field("byte_index", 8'(want.byte_index), 8'(byte_index));
			cmp_field("frame_last", 8'(want.frame_last), 8'(frame_last));
			cmp_field("discard_length", 8'(want.discard_length), 8'(discard_length));
		end
	endtask

	// Monitor: check output transactions, then track accepted input
	always @(posedge clk) begin : p_monitor
		if (!arst_n) begin
			in_fire = 1'b0;
		end else begin
			if (out_valid && out_ready)
				check_result();
			in_fire = in_valid && in_ready;
			if (in_fire)
				step_frame_tracker(hsfr_pkg::op_t'(operation), rx_byte);
		end
	end

	// Sender: hold until taken, then idle or offer the next transaction
	always @(negedge clk) begin : p_sender
		rx_item_t it;
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap = 0;
		end else if (in_valid && !in_fire) begin
			// hold payload until accepted
		end else if (send_gap > 0) begin
			in_valid <= 1'b0;
			send_gap--;
		end else if (rx_item_q.size() != 0) begin
			it = rx_item_q.pop_front();
			in_valid  <= 1'b1;
			operation <= it.op;
			rx_byte   <= it.data;
			send_gap  = (it.burst || !jitter_on) ? 0 : idle_len();
		end else begin
			in_valid <= 1'b0;
		end
	end

	// Receiver: long hold-off on request, random stalls otherwise
	always @(negedge clk) begin : p_receiver
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else if (hold_req != hold_done) begin
			out_ready <= 1'b0;
			hold_done++;
			hold_left = LONG_HOLD - 1;
		end else if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else begin
			out_ready <= 1'b1;
			if (jitter_on && $urandom_range(0, 3) == 0)
				stall_left = idle_len();
		end
	end

	task automatic put_item(input hsfr_pkg::op_t op, input logic [7:0] data);
		rx_item_t it;
		it.op    = op;
		it.data  = data;
		it.burst = burst_mode;
		rx_item_q.push_back(it);
		items_queued++;
	endtask

	task automatic put_byte(input logic [7:0] data);
		put_item(hsfr_pkg::OP_BYTE, data);
	endtask

	// Ticks carry a random, ignored byte
	task automatic put_ticks(input int n);
		repeat (n) put_item(hsfr_pkg::OP_TICK, 8'($urandom_range(0, 255)));
	endtask

	task automatic put_header();
		put_byte(hsfr_pkg::HDR_BYTE0);
		put_byte(hsfr_pkg::HDR_BYTE1);
		put_byte(hsfr_pkg::HDR_BYTE2);
	endtask

	function automatic logic [7:0] hunt_byte();
		case ($urandom_range(0, 3))
			0: return hsfr_pkg::HDR_BYTE0;
			1: return hsfr_pkg::HDR_BYTE1;
			2: return hsfr_pkg::HDR_BYTE2;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Header, then a full or partial body with tick gaps
	task automatic frame_burst();
		int body;
		int span;
		span = (tmo_now + 1 < TICK_SPAN) ? tmo_now + 1 : TICK_SPAN;
		repeat ($urandom_range(0, 2)) put_byte(hunt_byte());
		put_header();
		body = $urandom_range(0, 1) ? hsfr_pkg::FRAME_LENGTH - 3 :
			$urandom_range(0, hsfr_pkg::FRAME_LENGTH - 4);
		for (int k = 0; k < body; k++) begin
			if ($urandom_range(0, 4) == 0)
				put_ticks($urandom_range(0, span));
			put_byte(8'($urandom_range(0, 255)));
		end
		if (body < hsfr_pkg::FRAME_LENGTH - 3 && tmo_now < 20 && $urandom_range(0, 3) != 0)
			put_ticks(tmo_now + 1);
	endtask

	// Stray bytes and ticks, biased toward header bytes
	task automatic noise_burst();
		repeat ($urandom_range(1, 8)) begin
			if ($urandom_range(0, 3) == 0)
				put_ticks(1);
			else
				put_byte(hunt_byte());
		end
	endtask

	task automatic random_traffic(input int n);
		int start;
		start = items_queued;
		while (items_queued - start < n) begin
			if ($urandom_range(0, 9) < 7)
				frame_burst();
			else
				noise_burst();
		end
	endtask

	// Wait until all transactions are in and every result is out
	task automatic wait_quiet();
		while (rx_item_q.size() != 0 || in_valid || due_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_timeout(input logic [15:0] v);
		wait_quiet();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
		trk_timeout = v;
		tmo_now     = v;
	endtask

	// Run limit
	initial begin
		#20_000_000;
		$display("tb failed");
		$finish;
	end

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset timeout: tick while hunting, rejected and accepted bytes,
		// a full frame with extreme body bytes
		put_ticks(1);
		put_byte(8'hAA);
		put_byte(8'h00);
		put_byte(8'h01);
		put_byte(8'hFF);
		put_header();
		put_byte(8'h00); put_byte(8'hFF); put_byte(8'h55); put_byte(8'h01);
		put_byte(8'h00); put_byte(8'hAA); put_byte(8'h80); put_byte(8'h7F);
		put_byte(8'h01); put_byte(8'h55); put_byte(8'h00); put_byte(8'hFE);
		put_byte(8'h01); put_byte(8'hFF); put_byte(8'h10); put_byte(8'hEF);
		// Partial frame dropped at the reset timeout
		put_header();
		put_byte(8'h12);
		put_byte(8'h34);
		put_byte(8'h56);
		put_ticks(hsfr_pkg::GAP_TIMEOUT_RST + 1);

		// Zero timeout: discard on the first tick
		write_timeout(16'd0);
		put_header();
		put_byte(8'h5A);
		put_byte(8'hA5);
		put_ticks(2);

		// Timeout of one: a byte clears the gap count
		write_timeout(16'd1);
		put_header();
		put_byte(8'h33);
		put_ticks(1);
		put_byte(8'hCC);
		put_ticks(2);

		// Receiver holds off while the sender keeps offering
		write_timeout(16'd3);
		hold_req++;
		random_traffic(40);

		// Stretch with no idling on either side
		write_timeout(16'd1);
		jitter_on = 1'b0;
		random_traffic(30);
		wait_quiet();
		jitter_on = 1'b1;

		write_timeout(16'd300);
		random_traffic(30);

		write_timeout(16'($urandom_range(2, 10)));
		random_traffic(40);

		// Largest timeout: long tick gaps keep the frame alive
		write_timeout(16'hFFFF);
		burst_mode = 1'b1;
		put_header();
		put_byte(8'h9C);
		put_ticks(10);
		for (int k = 0; k < hsfr_pkg::FRAME_LENGTH - 4; k++)
			put_byte(8'($urandom_range(0, 255)));
		put_ticks(4);
		burst_mode = 1'b0;

		wait_quiet();
		if (mismatch_cnt == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
